[rtl/rdsaf_pkg.sv]
// Shared types and constants for the RDS alternative-frequency list decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rdsaf_pkg;

  localparam int CODE_W  = 8;
  localparam int KHZ_W   = 17;
  localparam int COUNT_W = 5;

  // AF code points
  localparam logic [CODE_W-1:0] CODE_FILL_A = 8'd205;
  localparam logic [CODE_W-1:0] CODE_FILL_B = 8'd224;
  localparam logic [CODE_W-1:0] CODE_CNT_LO = 8'd225;
  localparam logic [CODE_W-1:0] CODE_CNT_HI = 8'd249;
  localparam logic [CODE_W-1:0] CODE_LFMF   = 8'd250;
  localparam logic [CODE_W-1:0] FM_MAX      = 8'd204;
  localparam logic [CODE_W-1:0] LFMF_MAX    = 8'd135;
  localparam logic [CODE_W-1:0] LF_LAST     = 8'd15;

  // Frequency mapping
  localparam logic [KHZ_W-1:0] FM_BASE_KHZ   = 17'd87500;
  localparam logic [KHZ_W-1:0] FM_STEP_KHZ   = 17'd100;
  localparam logic [KHZ_W-1:0] LF_BASE_KHZ   = 17'd144;
  localparam logic [KHZ_W-1:0] MF_BASE_KHZ   = 17'd522;
  localparam logic [KHZ_W-1:0] LFMF_STEP_KHZ = 17'd9;

  typedef enum logic [2:0] {
    OUT_STORED    = 3'd0,
    OUT_FILLER    = 3'd1,
    OUT_COUNT_SET = 3'd2,
    OUT_LFMF_MARK = 3'd3,
    OUT_OVERFLOW  = 3'd4,
    OUT_INVALID   = 3'd5
  } outcome_t;

  // Result of converting one code to a frequency
  typedef struct packed {
    logic             valid;
    logic [KHZ_W-1:0] khz;
  } conv_t;

endpackage

`default_nettype wire

[rtl/rdsaf_khz.sv]
// Converts one AF code to kHz for the FM or LF/MF band and flags codes in range.
// Depends on rdsaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdsaf_khz (
  input  wire logic [rdsaf_pkg::CODE_W-1:0] code,
  input  wire logic                         lfmf,
  output rdsaf_pkg::conv_t                  conv
);
  import rdsaf_pkg::*;

  logic [KHZ_W-1:0] code_ext;
  logic [KHZ_W-1:0] fm_khz;
  logic [KHZ_W-1:0] lf_khz;
  logic [KHZ_W-1:0] mf_khz;

  assign code_ext = KHZ_W'(code);
  assign fm_khz   = FM_BASE_KHZ + code_ext * FM_STEP_KHZ;
  assign lf_khz   = LF_BASE_KHZ + code_ext * LFMF_STEP_KHZ;
  assign mf_khz   = MF_BASE_KHZ + (code_ext - KHZ_W'(LF_LAST)) * LFMF_STEP_KHZ;

  always_comb begin
    if (lfmf) begin
      conv.valid = (code != '0) && (code <= LFMF_MAX);
      conv.khz   = (code <= LF_LAST) ? lf_khz : mf_khz;
    end else begin
      conv.valid = (code != '0) && (code <= FM_MAX);
      conv.khz   = fm_khz;
    end
  end

endmodule

`default_nettype wire

[rtl/rds_alt_freq_list_decoder.sv]
// RDS alternative-frequency list decoder, top level.
// Depends on rdsaf_pkg and rdsaf_khz.
//
// Usage:
//   Input channel: in_valid / in_stall / in_af_code, one AF code byte per
//   transaction. Result channel: out_valid / out_stall and the result fields,
//   exactly one result transaction per input transaction, in order.
//   An accepted code sits in an input register; the edge that advances it runs
//   the conversion and list update and loads the result register, which raises
//   out_valid. Throughput is one code per cycle while the receiver does not
//   stall: list state updates in the same edge that loads the result register,
//   so the following code sees it immediately.
//   When the receiver stalls, the result register holds; one more code can
//   still be taken into the input register, after which in_stall rises until
//   the result is taken.
//   Synchronous reset (rst_n low) empties both registers, clears expected and
//   received counts, the LF/MF marker and the stored tuned/pending frequencies,
//   and sets the pair-check flag.
`timescale 1ns / 1ps
`default_nettype none

module rds_alt_freq_list_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [rdsaf_pkg::CODE_W-1:0]  in_af_code,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      rdsaf_pkg::outcome_t           out_outcome,
  output      logic [rdsaf_pkg::KHZ_W-1:0]   out_freq_khz,
  output      logic [rdsaf_pkg::COUNT_W-1:0] out_entry_index,
  output      logic [rdsaf_pkg::COUNT_W-1:0] out_received_count,
  output      logic [rdsaf_pkg::COUNT_W-1:0] out_expected_count,
  output      logic                          out_list_complete,
  output      logic                          out_method_b
);
  import rdsaf_pkg::*;

  logic                s1_valid_r;
  logic [CODE_W-1:0]   s1_code_r;
  logic                advance;
  logic                in_take;

  logic [COUNT_W-1:0]  exp_r, exp_nxt;
  logic [COUNT_W-1:0]  rcv_r, rcv_nxt;
  logic                lfmf_r, lfmf_nxt;
  logic [KHZ_W-1:0]    tuned_r, tuned_nxt;
  logic [KHZ_W-1:0]    pend_r, pend_nxt;
  logic                pairs_r, pairs_nxt;

  outcome_t            outcome_nxt;
  logic [KHZ_W-1:0]    freq_nxt;
  logic [COUNT_W-1:0]  index_nxt;

  logic                out_valid_r;
  outcome_t            out_outcome_r;
  logic [KHZ_W-1:0]    out_freq_r;
  logic [COUNT_W-1:0]  out_index_r;
  logic [COUNT_W-1:0]  out_rcv_r;
  logic [COUNT_W-1:0]  out_exp_r;
  logic                out_complete_r;
  logic                out_method_b_r;

  conv_t               conv;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  rdsaf_khz u_khz (
    .code (s1_code_r),
    .lfmf (lfmf_r),
    .conv (conv)
  );

  always_comb begin
    exp_nxt     = exp_r;
    rcv_nxt     = rcv_r;
    lfmf_nxt    = 1'b0;
    tuned_nxt   = tuned_r;
    pend_nxt    = pend_r;
    pairs_nxt   = pairs_r;
    freq_nxt    = '0;
    index_nxt   = '0;
    outcome_nxt = OUT_INVALID;
    if (conv.valid && (exp_r != '0)) begin
      if (rcv_r < exp_r) begin
        outcome_nxt = OUT_STORED;
        freq_nxt    = conv.khz;
        index_nxt   = rcv_r;
        rcv_nxt     = COUNT_W'(rcv_r + 5'd1);
        if (rcv_r == '0) begin
          tuned_nxt = conv.khz;
          pairs_nxt = 1'b1;
        end else if (rcv_r[0]) begin
          pend_nxt = conv.khz;
        end else if ((pend_r != tuned_r) && (conv.khz != tuned_r)) begin
          pairs_nxt = 1'b0;
        end
      end else begin
        outcome_nxt = OUT_OVERFLOW;
        exp_nxt     = '0;
        rcv_nxt     = '0;
        pairs_nxt   = 1'b1;
      end
    end else if ((s1_code_r == CODE_FILL_A) || (s1_code_r == CODE_FILL_B)) begin
      outcome_nxt = OUT_FILLER;
    end else if ((s1_code_r >= CODE_CNT_LO) && (s1_code_r <= CODE_CNT_HI)) begin
      outcome_nxt = OUT_COUNT_SET;
      exp_nxt     = COUNT_W'(s1_code_r - CODE_FILL_B);
      rcv_nxt     = '0;
      pairs_nxt   = 1'b1;
    end else if (s1_code_r == CODE_LFMF) begin
      outcome_nxt = OUT_LFMF_MARK;
      lfmf_nxt    = 1'b1;
    end else begin
      outcome_nxt = OUT_INVALID;
      exp_nxt     = '0;
      rcv_nxt     = '0;
      pairs_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      exp_r       <= '0;
      rcv_r       <= '0;
      lfmf_r      <= 1'b0;
      tuned_r     <= '0;
      pend_r      <= '0;
      pairs_r     <= 1'b1;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        exp_r       <= exp_nxt;
        rcv_r       <= rcv_nxt;
        lfmf_r      <= lfmf_nxt;
        tuned_r     <= tuned_nxt;
        pend_r      <= pend_nxt;
        pairs_r     <= pairs_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_code_r <= in_af_code;
    end
    if (advance) begin
      out_outcome_r  <= outcome_nxt;
      out_freq_r     <= freq_nxt;
      out_index_r    <= index_nxt;
      out_rcv_r      <= rcv_nxt;
      out_exp_r      <= exp_nxt;
      out_complete_r <= (rcv_nxt == exp_nxt) && (rcv_nxt != '0);
      out_method_b_r <= exp_nxt[0] && (rcv_nxt >= 5'd3) && pairs_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_freq_khz       = out_freq_r;
  assign out_entry_index    = out_index_r;
  assign out_received_count = out_rcv_r;
  assign out_expected_count = out_exp_r;
  assign out_list_complete  = out_complete_r;
  assign out_method_b       = out_method_b_r;

endmodule

`default_nettype wire

[rtl/rdsaf_checker.sv]
// Port-level assertions for rds_alt_freq_list_decoder, bound to the top level.
// Depends on rdsaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdsaf_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [2:0]                    out_outcome,
  input wire logic [rdsaf_pkg::KHZ_W-1:0]   out_freq_khz,
  input wire logic [rdsaf_pkg::COUNT_W-1:0] out_entry_index,
  input wire logic [rdsaf_pkg::COUNT_W-1:0] out_received_count,
  input wire logic [rdsaf_pkg::COUNT_W-1:0] out_expected_count,
  input wire logic                          out_list_complete,
  input wire logic                          out_method_b
);
  import rdsaf_pkg::*;

  // A stored entry lands at the previous end of the list.
  a_store_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == OUT_STORED) |->
      (out_received_count == COUNT_W'(out_entry_index + 5'd1)) &&
      (out_received_count <= out_expected_count))
    else $error("stored entry index does not match received count");

  // No frequency or index reported unless something was stored.
  a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome != OUT_STORED) |->
      (out_freq_khz == '0) && (out_entry_index == '0))
    else $error("frequency reported without a store");

  // Clearing outcomes leave an empty list with no announced length.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_outcome == OUT_OVERFLOW) || (out_outcome == OUT_INVALID)) |->
      (out_received_count == '0) && (out_expected_count == '0) && !out_method_b)
    else $error("list not empty after clear");

  // Method B needs an odd announced length and at least three entries.
  a_method_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_method_b |->
      out_expected_count[0] && (out_received_count >= 5'd3))
    else $error("method B flag without odd length and three entries");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_outcome) && $stable(out_freq_khz) &&
      $stable(out_received_count))
    else $error("stalled result transaction changed");

endmodule

bind rds_alt_freq_list_decoder rdsaf_checker u_rdsaf_checker (.*);

`default_nettype wire
